// File: hdl/psc_pkg.sv
// Package with shared types, widths and register codes of the PID speed controller.
`timescale 1ns / 1ps

package psc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DSIGN,
    ST_GAIN,
    ST_SUM,
    ST_CLAMP
  } state_t;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_GAIN_P       = 3'd0;
  localparam logic [2:0] REG_GAIN_I       = 3'd1;
  localparam logic [2:0] REG_GAIN_D       = 3'd2;
  localparam logic [2:0] REG_TICK_PERIOD  = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_MAX = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_MIN = 3'd5;
  localparam logic [2:0] REG_DRIVE_MAX    = 3'd6;
  localparam logic [2:0] REG_DRIVE_MIN    = 3'd7;

  // Reset values of the registers.
  localparam logic signed [23:0] GAIN_P_RST       = 24'sd1835008;
  localparam logic signed [23:0] GAIN_I_RST       = 24'sd8520;
  localparam logic signed [23:0] GAIN_D_RST       = 24'sd45875;
  localparam logic [15:0]        TICK_PERIOD_RST  = 16'd6554;
  localparam logic signed [31:0] INTEGRAL_MAX_RST = 32'sh7fff_ffff;
  localparam logic signed [31:0] INTEGRAL_MIN_RST = 32'sh8000_0000;
  localparam logic signed [31:0] DRIVE_MAX_RST    = 32'sd6553600;
  localparam logic signed [31:0] DRIVE_MIN_RST    = -32'sd6553600;

  // Iteration counts of the serial units.
  localparam logic [5:0] DIV_LAST   = 6'd32;  // 33 quotient bits
  localparam logic [5:0] IMUL_STEPS = 6'd16;  // tick period bits
  localparam logic [5:0] GAIN_LAST  = 6'd23;  // gain bits, top one carries negative weight

endpackage

// File: hdl/pid_speed_controller_core.sv
// PID speed controller with integral clamp, built from bit-serial multipliers and divider.
`timescale 1ns / 1ps

//  channel   signals                                  direction
//  input     in_valid, in_ready, target_speed,         in, out, in, in
//            measured_speed
//  output    out_valid, out_ready, drive_value         out, in, out
//  config    cfg_we, cfg_index, cfg_data               in
//
//  Each tick runs a 33-step restoring divider for the derivative (the error times
//  tick period product runs alongside it), then a 24-step pass over the gain bits,
//  before the next input can be taken.
//  Result sits in an output register; a stalled output only holds the block once
//  the following tick has finished. Reset (synchronous) clears the state and loads
//  the register defaults.

module pid_speed_controller_core
  import psc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        target_speed,
  input  logic [15:0]        measured_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // Configuration registers.
  logic signed [23:0] gain_p, gain_i, gain_d;
  logic [15:0]        tick_period;
  logic signed [31:0] integral_max, integral_min, drive_max, drive_min;

  // Controller state.
  logic signed [31:0] integral_sum;
  logic signed [16:0] last_error;

  state_t state, state_next;
  logic [5:0] cnt;

  logic signed [16:0] err;
  logic signed [17:0] diff;
  logic               neg;

  // Divider: dividend shifts out of the top of dq while quotient bits enter below.
  logic [32:0] dq;
  logic [15:0] rem;

  // Error times tick period.
  logic signed [32:0] imul_acc, imul_mc;
  logic [15:0]        imul_mp;
  logic signed [33:0] isum;

  // Gain pass.
  logic [23:0]        gp_sh, gi_sh, gd_sh;
  logic signed [57:0] mc_p, mc_d, acc_pd;
  logic signed [55:0] mc_i, acc_i;
  logic signed [58:0] total;

  logic in_fire, out_load;

  // Combinational datapath values.
  logic signed [16:0] err_in;
  logic signed [17:0] diff_in;
  logic [17:0]        diff_abs;
  logic [16:0]        rem_sh;
  logic [16:0]        rem_dif;
  logic               sub_ok;
  logic signed [33:0] deriv_val;
  logic signed [31:0] isum_clamped;
  logic signed [31:0] drive_clamped;
  logic signed [57:0] term_p, term_d;
  logic signed [55:0] term_i;
  logic               gain_last;

  assign err_in   = $signed({1'b0, target_speed}) - $signed({1'b0, measured_speed});
  assign diff_in  = $signed({err_in[16], err_in}) - $signed({last_error[16], last_error});
  assign diff_abs = diff[17] ? (~diff + 18'sd1) : diff;

  assign rem_sh  = {rem, dq[32]};
  assign sub_ok  = rem_sh >= {1'b0, tick_period};
  assign rem_dif = rem_sh - {1'b0, tick_period};

  always_comb begin
    if (tick_period == 16'd0) begin
      deriv_val = '0;
    end else if (neg) begin
      deriv_val = -$signed({1'b0, dq});
    end else begin
      deriv_val = $signed({1'b0, dq});
    end
  end

  // Upper limit tested first: inverted limits yield max for sums above it, else min.
  always_comb begin
    priority if (isum > $signed({{2{integral_max[31]}}, integral_max})) begin
      isum_clamped = integral_max;
    end else if (isum < $signed({{2{integral_min[31]}}, integral_min})) begin
      isum_clamped = integral_min;
    end else begin
      isum_clamped = isum[31:0];
    end
  end

  always_comb begin
    priority if (total > $signed({{27{drive_max[31]}}, drive_max})) begin
      drive_clamped = drive_max;
    end else if (total < $signed({{27{drive_min[31]}}, drive_min})) begin
      drive_clamped = drive_min;
    end else begin
      drive_clamped = total[31:0];
    end
  end

  assign gain_last = cnt == GAIN_LAST;
  assign term_p    = gp_sh[0] ? mc_p : '0;
  assign term_d    = gd_sh[0] ? mc_d : '0;
  assign term_i    = gi_sh[0] ? mc_i : '0;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_PREP;
      ST_PREP:  state_next = ST_DIV;
      ST_DIV:   if (cnt == DIV_LAST) state_next = ST_DSIGN;
      ST_DSIGN: state_next = ST_GAIN;
      ST_GAIN:  if (gain_last) state_next = ST_SUM;
      ST_SUM:   state_next = ST_CLAMP;
      ST_CLAMP: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs and strobes.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_CLAMP: out_load = !out_valid || out_ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RST;
      gain_i       <= GAIN_I_RST;
      gain_d       <= GAIN_D_RST;
      tick_period  <= TICK_PERIOD_RST;
      integral_max <= INTEGRAL_MAX_RST;
      integral_min <= INTEGRAL_MIN_RST;
      drive_max    <= DRIVE_MAX_RST;
      drive_min    <= DRIVE_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:       gain_p       <= cfg_data[23:0];
        REG_GAIN_I:       gain_i       <= cfg_data[23:0];
        REG_GAIN_D:       gain_d       <= cfg_data[23:0];
        REG_TICK_PERIOD:  tick_period  <= cfg_data[15:0];
        REG_INTEGRAL_MAX: integral_max <= cfg_data;
        REG_INTEGRAL_MIN: integral_min <= cfg_data;
        REG_DRIVE_MAX:    drive_max    <= cfg_data;
        REG_DRIVE_MIN:    drive_min    <= cfg_data;
        default:          gain_p       <= gain_p;
      endcase
    end
  end

  // Controller state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      last_error   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_PREP) begin
        last_error <= err;
      end
      if (state == ST_DIV && cnt == IMUL_STEPS + 6'd1) begin
        integral_sum <= isum_clamped;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_value <= drive_clamped;
    end
  end

  // Serial datapath.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      err  <= err_in;
      diff <= diff_in;
    end

    unique case (state)
      ST_PREP: begin
        neg      <= diff[17];
        dq       <= {diff_abs[16:0], 16'd0};
        rem      <= '0;
        imul_acc <= '0;
        imul_mc  <= $signed({{16{err[16]}}, err});
        imul_mp  <= tick_period;
        cnt      <= '0;
      end
      ST_DIV: begin
        rem <= sub_ok ? rem_dif[15:0] : rem_sh[15:0];
        dq  <= {dq[31:0], sub_ok};
        cnt <= cnt + 6'd1;
        if (cnt < IMUL_STEPS) begin
          if (imul_mp[0]) begin
            imul_acc <= imul_acc + imul_mc;
          end
          imul_mc <= imul_mc <<< 1;
          imul_mp <= imul_mp >> 1;
        end
        if (cnt == IMUL_STEPS) begin
          isum <= $signed({{2{integral_sum[31]}}, integral_sum})
                + $signed({imul_acc[32], imul_acc});
        end
      end
      ST_DSIGN: begin
        mc_d   <= $signed({{24{deriv_val[33]}}, deriv_val});
        mc_p   <= $signed({{41{err[16]}}, err});
        mc_i   <= $signed({{24{integral_sum[31]}}, integral_sum});
        gp_sh  <= gain_p;
        gi_sh  <= gain_i;
        gd_sh  <= gain_d;
        acc_pd <= '0;
        acc_i  <= '0;
        cnt    <= '0;
      end
      ST_GAIN: begin
        // The top gain bit is the sign, so its partial product is subtracted.
        if (gain_last) begin
          acc_pd <= acc_pd - term_p - term_d;
          acc_i  <= acc_i - term_i;
        end else begin
          acc_pd <= acc_pd + term_p + term_d;
          acc_i  <= acc_i + term_i;
        end
        mc_p  <= mc_p <<< 1;
        mc_d  <= mc_d <<< 1;
        mc_i  <= mc_i <<< 1;
        gp_sh <= gp_sh >> 1;
        gi_sh <= gi_sh >> 1;
        gd_sh <= gd_sh >> 1;
        cnt   <= cnt + 6'd1;
      end
      ST_SUM: begin
        // Dropping the low 16 bits of the integral term floors it.
        total <= $signed({acc_pd[57], acc_pd})
               + $signed({{19{acc_i[55]}}, acc_i[55:16]});
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the PID speed controller core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import psc_pkg::*;

  localparam int RAND_PHASES     = 13;
  localparam int TICKS_PER_PHASE = 100;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 70;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        target_speed = 16'd0;
  logic [15:0]        measured_speed = 16'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] drive_value;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = REG_GAIN_P;
  logic [31:0]        cfg_data = 32'd0;

  pid_speed_controller_core DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Controller state and settings as the testbench expects them.
  logic signed [23:0] kp = GAIN_P_RST;
  logic signed [23:0] ki = GAIN_I_RST;
  logic signed [23:0] kd = GAIN_D_RST;
  logic [15:0]        dt = TICK_PERIOD_RST;
  logic signed [31:0] imax = INTEGRAL_MAX_RST;
  logic signed [31:0] imin = INTEGRAL_MIN_RST;
  logic signed [31:0] dmax = DRIVE_MAX_RST;
  logic signed [31:0] dmin = DRIVE_MIN_RST;
  logic signed [31:0] integ = 32'sd0;
  logic signed [16:0] prev_err = 17'sd0;

  logic signed [31:0] pending_drive [$];
  logic               calm = 1'b0;
  int unsigned        cycle_count = 0;
  int                 fail_count = 0;
  int                 ticks_sent = 0;
  int                 drives_checked = 0;
  int                 reg_writes = 0;

  typedef struct packed {
    logic        is_write;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [15:0] tgt;
    logic [15:0] meas;
    logic        typed;
    logic [31:0] want;
  } plan_row_t;

  plan_row_t plan_rows [0:46];

  // Advances the controller by one tick and returns the clamped drive.
  function automatic logic signed [31:0] next_drive(input logic [15:0] tgt,
                                                    input logic [15:0] meas);
    longint err, acc, rate, raw;
    err = longint'({48'd0, tgt}) - longint'({48'd0, meas});
    acc = longint'(integ) + err * longint'({48'd0, dt});
    if (acc > longint'(imax)) acc = longint'(imax);
    else if (acc < longint'(imin)) acc = longint'(imin);
    integ = acc[31:0];
    if (dt != 16'd0) rate = ((err - longint'(prev_err)) * 65536) / longint'({48'd0, dt});
    else rate = 0;
    raw = longint'(kp) * err + ((longint'(ki) * longint'(integ)) >>> 16)
        + longint'(kd) * rate;
    if (raw > longint'(dmax)) raw = longint'(dmax);
    else if (raw < longint'(dmin)) raw = longint'(dmin);
    prev_err = err[16:0];
    return raw[31:0];
  endfunction

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      REG_GAIN_P:       kp = data[23:0];
      REG_GAIN_I:       ki = data[23:0];
      REG_GAIN_D:       kd = data[23:0];
      REG_TICK_PERIOD:  dt = data[15:0];
      REG_INTEGRAL_MAX: imax = data;
      REG_INTEGRAL_MIN: imin = data;
      REG_DRIVE_MAX:    dmax = data;
      REG_DRIVE_MIN:    dmin = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Holds the input off until every outstanding drive value has been seen.
  task automatic wait_for_drives();
    in_valid = 1'b0;
    while (pending_drive.size() != 0) @(negedge clk);
  endtask

  task automatic offer_tick(input logic [15:0] tgt, input logic [15:0] meas,
                            input logic typed, input logic [31:0] want);
    logic signed [31:0] model_drive;
    while (!calm && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    // A rare long gap lets the next offer land anywhere in the block's busy window.
    if (!calm && $urandom_range(99) < 3) begin
      in_valid = 1'b0;
      repeat ($urandom_range(90, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    target_speed = tgt;
    measured_speed = meas;
    do @(posedge clk); while (!in_ready);
    model_drive = next_drive(tgt, meas);
    pending_drive.push_back(typed ? want : model_drive);
    ticks_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 16);

  always @(posedge clk) begin : check_drive
    logic signed [31:0] head;
    if (!rst && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected drive transfer: %0d", drive_value);
      end else begin
        head = pending_drive.pop_front();
        drives_checked++;
        if (drive_value !== head) begin
          fail_count++;
          if (fail_count <= 10)
            $display("drive mismatch on result %0d: expected %0d, got %0d",
                     drives_checked, head, drive_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drive values outstanding",
               cycle_count, pending_drive.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Columns: write, register, data, target, measured, typed expectation, drive.
  initial plan_rows = '{
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd0, 1'b1, 32'h0000_0000},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd65535, 16'd0, 1'b1, 32'h0064_0000},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd65535, 1'b1, 32'hff9c_0000},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd1000, 16'd1000, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'haaaa, 16'h5555, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'h5555, 16'haaaa, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd300, 16'd299, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_P, 32'h0001_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_I, 32'h0000_8000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_D, 32'h0000_0100, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_DRIVE_MAX, 32'h7fff_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_DRIVE_MIN, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd100, 16'd90, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd90, 16'd100, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd12345, 16'd12345, 1'b0, 32'h0},
    '{1'b1, REG_TICK_PERIOD, 32'h0000_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd500, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd500, 1'b0, 32'h0},
    '{1'b1, REG_TICK_PERIOD, 32'h0000_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_INTEGRAL_MAX, 32'h000a_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_INTEGRAL_MIN, 32'hfff6_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd65535, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd65535, 1'b0, 32'h0},
    '{1'b1, REG_INTEGRAL_MAX, 32'hfff6_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_INTEGRAL_MIN, 32'h000a_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_DRIVE_MAX, 32'hfff0_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_DRIVE_MIN, 32'h0010_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_TICK_PERIOD, 32'h0000_0001, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd10, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd10, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd7, 16'd7, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_P, 32'h0080_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_I, 32'h007f_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_D, 32'h0080_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_INTEGRAL_MAX, 32'h7fff_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_INTEGRAL_MIN, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_DRIVE_MAX, 32'h7fff_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_DRIVE_MIN, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_TICK_PERIOD, 32'h0000_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd65535, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd65535, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd1, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_GAIN_D, 32'h007f_ffff, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b1, REG_TICK_PERIOD, 32'h0000_0001, 16'd0, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd65535, 16'd0, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd65535, 1'b0, 32'h0},
    '{1'b0, REG_GAIN_P, 32'h0, 16'd0, 16'd0, 1'b0, 32'h0}
  };

  initial begin
    logic [31:0] setting;
    logic [15:0] tgt;
    logic [15:0] meas;
    logic [2:0]  reg_idx;
    int          roll;
    int          near;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_write) begin
        wait_for_drives();
        write_register(plan_rows[i].idx, plan_rows[i].data);
      end else begin
        offer_tick(plan_rows[i].tgt, plan_rows[i].meas, plan_rows[i].typed,
                   plan_rows[i].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_for_drives();
      calm = (p == 4 || p == 5);
      for (int r = 0; r < 8; r++) begin
        reg_idx = 3'(r);
        roll = $urandom_range(9);
        case (reg_idx)
          REG_GAIN_P, REG_GAIN_I, REG_GAIN_D: begin
            case (roll)
              0: setting = 32'hff80_0000;
              1: setting = 32'h007f_ffff;
              2, 3, 4, 5: setting = $urandom_range(32'h0008_0000) - 32'h0004_0000;
              default: begin
                setting = $urandom;
                setting[31:24] = {8{setting[23]}};
              end
            endcase
            // Bits above the register width are don't-care on the write port.
            if ($urandom_range(7) == 0) setting[31:24] = 8'($urandom);
          end
          REG_TICK_PERIOD: begin
            case (roll)
              0: setting = 32'd0;
              1: setting = 32'd1;
              2: setting = 32'h0000_ffff;
              3: setting = {16'd0, TICK_PERIOD_RST};
              4, 5, 6: setting = $urandom_range(64, 1);
              default: setting = $urandom_range(32'h0000_ffff);
            endcase
            if ($urandom_range(7) == 0) setting[31:16] = 16'($urandom);
          end
          REG_INTEGRAL_MAX: begin
            case (roll)
              0: setting = 32'h7fff_ffff;
              1: setting = 32'h8000_0000;
              2, 3, 4, 5: setting = $urandom_range(32'h0100_0000);
              6: setting = -$urandom_range(32'h0100_0000);
              default: setting = $urandom;
            endcase
          end
          REG_INTEGRAL_MIN: begin
            case (roll)
              0: setting = 32'h8000_0000;
              1: setting = 32'h7fff_ffff;
              2, 3, 4, 5: setting = -$urandom_range(32'h0100_0000);
              6: setting = $urandom_range(32'h0100_0000);
              default: setting = $urandom;
            endcase
          end
          REG_DRIVE_MAX: begin
            case (roll)
              0: setting = 32'h7fff_ffff;
              1: setting = DRIVE_MAX_RST;
              2, 3, 4, 5: setting = $urandom_range(32'h1000_0000);
              6: setting = 32'h8000_0000;
              default: setting = $urandom;
            endcase
          end
          default: begin
            case (roll)
              0: setting = 32'h8000_0000;
              1: setting = DRIVE_MIN_RST;
              2, 3, 4, 5: setting = -$urandom_range(32'h1000_0000);
              6: setting = 32'h7fff_ffff;
              default: setting = $urandom;
            endcase
          end
        endcase
        write_register(reg_idx, setting);
      end

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(99) == 0) wait_for_drives();
        meas = 16'($urandom_range(16'hffff));
        roll = $urandom_range(99);
        if (roll < 50) begin
          tgt = 16'($urandom_range(16'hffff));
        end else if (roll < 85) begin
          // Small errors keep the drive inside the limits more often.
          near = int'(meas) + int'($urandom_range(128)) - 64;
          tgt = (near < 0) ? 16'd0 : (near > 65535) ? 16'hffff : 16'(near);
        end else begin
          case ($urandom_range(3))
            0: tgt = 16'd0;
            1: tgt = 16'hffff;
            2: tgt = meas;
            default: begin
              tgt = 16'($urandom_range(1)) * 16'hffff;
              meas = ~tgt;
            end
          endcase
        end
        offer_tick(tgt, meas, 1'b0, 32'h0);
      end
    end

    wait_for_drives();
    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d speed ticks: a directed table and %0d random setting phases, %0d writes.",
             ticks_sent, RAND_PHASES, reg_writes);
    $display("Checked %0d drive values; %0d failures.", drives_checked, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
